// ===== hdl/nvc_pkg.sv =====
package nvc_pkg;

    // Default component width (signed Q1.15)
    localparam int COMPONENT_BITS_DEF = 16;

    // Share scale and fold constants
    localparam int SHARE_SCALE = 126;
    localparam int FOLD_BASE   = 127;
    localparam int FOLD_LIMIT  = 64;

    // Quotient bits: shares never exceed SHARE_SCALE
    localparam int QBITS = 7;
    // First share field width (bits 12..7)
    localparam int A_BITS = 6;
    // Output code width
    localparam int CODE_BITS = 16;

    // Per-beat sign and zero flags that ride along the divider chain
    typedef struct packed {
        logic sx;
        logic sy;
        logic sz;
        logic zero;
    } nvc_flags_t;

endpackage

// ===== hdl/nvc_front.sv =====
// Front cell: signs, magnitudes, sum and scaled numerators
module nvc_front #(
    parameter int COMPONENT_BITS = nvc_pkg::COMPONENT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        valid_in,
    input  logic [COMPONENT_BITS-1:0]   comp_x,
    input  logic [COMPONENT_BITS-1:0]   comp_y,
    input  logic [COMPONENT_BITS-1:0]   comp_z,
    output logic                        valid_reg,
    output nvc_pkg::nvc_flags_t         flags_reg,
    output logic [COMPONENT_BITS+5:0]   num_a_reg,
    output logic [COMPONENT_BITS+5:0]   num_b_reg,
    output logic [COMPONENT_BITS:0]     sum_reg
);

    localparam int W     = COMPONENT_BITS;
    localparam int SUM_W = W + 1;
    localparam int NUM_W = W + 6;

    logic [W-1:0]        mag_x;
    logic [W-1:0]        mag_y;
    logic [W-1:0]        mag_z;
    logic [SUM_W-1:0]    sum_next;
    logic [NUM_W-1:0]    num_a_next;
    logic [NUM_W-1:0]    num_b_next;
    nvc_pkg::nvc_flags_t flags_next;

    // Magnitudes; the most negative value maps to 2^(W-1) exactly
    assign mag_x = comp_x[W-1] ? (~comp_x + W'(1)) : comp_x;
    assign mag_y = comp_y[W-1] ? (~comp_y + W'(1)) : comp_y;
    assign mag_z = comp_z[W-1] ? (~comp_z + W'(1)) : comp_z;

    assign sum_next = SUM_W'(mag_x) + SUM_W'(mag_y) + SUM_W'(mag_z);

    // 126*m as 128*m - 2*m
    assign num_a_next = (NUM_W'(mag_x) << 7) - (NUM_W'(mag_x) << 1);
    assign num_b_next = (NUM_W'(mag_y) << 7) - (NUM_W'(mag_y) << 1);

    always_comb
    begin
        flags_next.sx   = comp_x[W-1];
        flags_next.sy   = comp_y[W-1];
        flags_next.sz   = comp_z[W-1];
        flags_next.zero = (sum_next == '0);
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags_reg <= flags_next;
            num_a_reg <= num_a_next;
            num_b_reg <= num_b_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

// ===== hdl/nvc_div_cell.sv =====
// Divider cell: one restoring step, one quotient bit for each share
module nvc_div_cell #(
    parameter int COMPONENT_BITS = nvc_pkg::COMPONENT_BITS_DEF,
    parameter int STEP           = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          valid_in,
    input  nvc_pkg::nvc_flags_t           flags_in,
    input  logic [COMPONENT_BITS+5:0]     rem_a_in,
    input  logic [COMPONENT_BITS+5:0]     rem_b_in,
    input  logic [COMPONENT_BITS:0]       div_in,
    input  logic [nvc_pkg::QBITS-1:0]     q_a_in,
    input  logic [nvc_pkg::QBITS-1:0]     q_b_in,
    output logic                          valid_reg,
    output nvc_pkg::nvc_flags_t           flags_reg,
    output logic [COMPONENT_BITS+5:0]     rem_a_reg,
    output logic [COMPONENT_BITS+5:0]     rem_b_reg,
    output logic [COMPONENT_BITS:0]       div_reg,
    output logic [nvc_pkg::QBITS-1:0]     q_a_reg,
    output logic [nvc_pkg::QBITS-1:0]     q_b_reg
);

    localparam int NUM_W = COMPONENT_BITS + 6;
    localparam int CMP_W = COMPONENT_BITS + nvc_pkg::QBITS;

    logic [CMP_W-1:0]             div_sh;
    logic [CMP_W-1:0]             diff_a;
    logic [CMP_W-1:0]             diff_b;
    logic                         take_a;
    logic                         take_b;
    logic [NUM_W-1:0]             rem_a_next;
    logic [NUM_W-1:0]             rem_b_next;
    logic [nvc_pkg::QBITS-1:0]    q_a_next;
    logic [nvc_pkg::QBITS-1:0]    q_b_next;

    // Divisor aligned to this quotient bit
    assign div_sh = CMP_W'(div_in) << STEP;

    // Trial subtract and restore
    assign take_a = CMP_W'(rem_a_in) >= div_sh;
    assign take_b = CMP_W'(rem_b_in) >= div_sh;
    assign diff_a = CMP_W'(rem_a_in) - div_sh;
    assign diff_b = CMP_W'(rem_b_in) - div_sh;

    assign rem_a_next = take_a ? diff_a[NUM_W-1:0] : rem_a_in;
    assign rem_b_next = take_b ? diff_b[NUM_W-1:0] : rem_b_in;

    always_comb
    begin
        q_a_next       = q_a_in;
        q_b_next       = q_b_in;
        q_a_next[STEP] = take_a;
        q_b_next[STEP] = take_b;
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags_reg <= flags_in;
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
            div_reg   <= div_in;
            q_a_reg   <= q_a_next;
            q_b_reg   <= q_b_next;
        end
    end

endmodule

// ===== hdl/nvc_pack.sv =====
// Output cell: fold, pack and hold the result beat
module nvc_pack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          valid_in,
    input  nvc_pkg::nvc_flags_t           flags_in,
    input  logic [nvc_pkg::QBITS-1:0]     q_a_in,
    input  logic [nvc_pkg::QBITS-1:0]     q_b_in,
    output logic                          valid_reg,
    output logic [nvc_pkg::CODE_BITS-1:0] code_reg,
    output logic                          zero_reg
);

    localparam logic [nvc_pkg::QBITS-1:0] FOLD_BASE_Q  = nvc_pkg::QBITS'(nvc_pkg::FOLD_BASE);
    localparam logic [nvc_pkg::QBITS-1:0] FOLD_LIMIT_Q = nvc_pkg::QBITS'(nvc_pkg::FOLD_LIMIT);
    localparam int LOW_BITS = nvc_pkg::CODE_BITS - 3;

    logic                          fold;
    logic [nvc_pkg::QBITS-1:0]     a_f;
    logic [nvc_pkg::QBITS-1:0]     b_f;
    logic [nvc_pkg::CODE_BITS-1:0] code_next;

    // Fold into the lower half when the first share is large
    assign fold = q_a_in >= FOLD_LIMIT_Q;
    assign a_f  = fold ? (FOLD_BASE_Q - q_a_in) : q_a_in;
    assign b_f  = fold ? (FOLD_BASE_Q - q_b_in) : q_b_in;

    // Zero vector carries the signs only
    always_comb
    begin
        if (flags_in.zero)
            code_next = {flags_in.sx, flags_in.sy, flags_in.sz, LOW_BITS'(0)};
        else
            code_next = {flags_in.sx, flags_in.sy, flags_in.sz,
                         a_f[nvc_pkg::A_BITS-1:0], b_f};
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            code_reg <= code_next;
            zero_reg <= flags_in.zero;
        end
    end

endmodule

// ===== hdl/normal_vector_compress_core.sv =====
// Packs a signed three-component direction vector into a 16-bit code: signs of
// x, y, z in bits 15..13, the folded x share floor(126|x|/s) in bits 12..7 and
// the y share, folded alike, in bits 6..0, with s = |x|+|y|+|z|. An all-zero
// vector returns only the sign bits (all zero) and raises zero_vector. One beat
// is taken per cycle while the chain is not stalled. The beat passes nine
// registers: the front cell, loaded on the accepting edge, a chain of seven
// restoring divider cells that each resolve one quotient bit of both shares,
// and the output register. The whole chain stalls together while a result
// waits at the output, so in_ready follows out_ready then.
module normal_vector_compress_core #(
    parameter int COMPONENT_BITS = nvc_pkg::COMPONENT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [COMPONENT_BITS-1:0]     comp_x,
    input  logic [COMPONENT_BITS-1:0]     comp_y,
    input  logic [COMPONENT_BITS-1:0]     comp_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nvc_pkg::CODE_BITS-1:0] packed_code,
    output logic                          zero_vector
);

    localparam int NUM_W = COMPONENT_BITS + 6;
    localparam int SUM_W = COMPONENT_BITS + 1;
    localparam int NQ    = nvc_pkg::QBITS;

    logic                      adv;
    logic                      valid_s [NQ+1];
    nvc_pkg::nvc_flags_t       flags_s [NQ+1];
    logic [NUM_W-1:0]          rem_a_s [NQ+1];
    logic [NUM_W-1:0]          rem_b_s [NQ+1];
    logic [SUM_W-1:0]          div_s   [NQ+1];
    logic [NQ-1:0]             q_a_s   [NQ+1];
    logic [NQ-1:0]             q_b_s   [NQ+1];

    // Whole chain moves when the output slot is free or being drained
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    nvc_front #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (in_valid),
        .comp_x    (comp_x),
        .comp_y    (comp_y),
        .comp_z    (comp_z),
        .valid_reg (valid_s[0]),
        .flags_reg (flags_s[0]),
        .num_a_reg (rem_a_s[0]),
        .num_b_reg (rem_b_s[0]),
        .sum_reg   (div_s[0])
    );

    assign q_a_s[0] = '0;
    assign q_b_s[0] = '0;

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < NQ; k++)
    begin : g_cell
        nvc_div_cell #(
            .COMPONENT_BITS (COMPONENT_BITS),
            .STEP           (NQ - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (valid_s[k]),
            .flags_in  (flags_s[k]),
            .rem_a_in  (rem_a_s[k]),
            .rem_b_in  (rem_b_s[k]),
            .div_in    (div_s[k]),
            .q_a_in    (q_a_s[k]),
            .q_b_in    (q_b_s[k]),
            .valid_reg (valid_s[k+1]),
            .flags_reg (flags_s[k+1]),
            .rem_a_reg (rem_a_s[k+1]),
            .rem_b_reg (rem_b_s[k+1]),
            .div_reg   (div_s[k+1]),
            .q_a_reg   (q_a_s[k+1]),
            .q_b_reg   (q_b_s[k+1])
        );
    end

    nvc_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (valid_s[NQ]),
        .flags_in  (flags_s[NQ]),
        .q_a_in    (q_a_s[NQ]),
        .q_b_in    (q_b_s[NQ]),
        .valid_reg (out_valid),
        .code_reg  (packed_code),
        .zero_reg  (zero_vector)
    );

endmodule

// ===== tb/normal_vector_compress_core_tb.sv =====
module normal_vector_compress_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W          = nvc_pkg::COMPONENT_BITS_DEF;
    localparam int N_RANDOM   = 550;
    localparam int STALL_MAX  = 4000;
    localparam int DRAIN_WAIT = 20;

    // One input vector as it sits on the pins
    typedef struct packed {
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] z;
    } normal_t;

    // One packed result
    typedef struct packed {
        logic [nvc_pkg::CODE_BITS-1:0] code;
        logic                          zero;
    } packed_normal_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [W-1:0]                  comp_x = '0;
    logic [W-1:0]                  comp_y = '0;
    logic [W-1:0]                  comp_z = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [nvc_pkg::CODE_BITS-1:0] packed_code;
    logic                          zero_vector;

    normal_t        vectors_to_send[$];
    packed_normal_t expected_codes[$];

    int total_vectors = 0;
    int beats_in      = 0;
    int beats_out     = 0;
    int errors        = 0;
    int stall_cycles  = 0;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_vector;
    packed_normal_t want;

    normal_vector_compress_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .comp_x     (comp_x),
        .comp_y     (comp_y),
        .comp_z     (comp_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .packed_code(packed_code),
        .zero_vector(zero_vector)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Magnitude of a two's-complement component, exact for the most negative value
    function automatic longint unsigned comp_mag(logic [W-1:0] v);
        logic [W:0] m;
        m = v[W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
        return longint'(m);
    endfunction

    // Expected code: sign bits, then the folded x and y shares of the L1 norm
    function automatic packed_normal_t pack_normal(logic [W-1:0] x, logic [W-1:0] y,
                                                   logic [W-1:0] z);
        packed_normal_t   r;
        longint unsigned  ax, ay, az, s, a, b;
        ax = comp_mag(x);
        ay = comp_mag(y);
        az = comp_mag(z);
        s  = ax + ay + az;
        r.code = '0;
        r.code[15] = x[W-1];
        r.code[14] = y[W-1];
        r.code[13] = z[W-1];
        r.zero = 1'b0;
        if (s == 0)
        begin
            r.zero = 1'b1;
            return r;
        end
        a = (nvc_pkg::SHARE_SCALE * ax) / s;
        b = (nvc_pkg::SHARE_SCALE * ay) / s;
        if (a >= nvc_pkg::FOLD_LIMIT)
        begin
            a = nvc_pkg::FOLD_BASE - a;
            b = nvc_pkg::FOLD_BASE - b;
        end
        r.code[12:7] = a[5:0];
        r.code[6:0]  = b[6:0];
        return r;
    endfunction

    // Magnitude with a random sign
    function automatic logic [W-1:0] signed_comp(int unsigned mag);
        logic [W-1:0] v;
        v = mag[W-1:0];
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    function automatic logic [W-1:0] extreme_comp();
        logic [W-1:0] picks[6];
        picks[0] = {1'b1, {(W-1){1'b0}}};
        picks[1] = {1'b1, {(W-2){1'b0}}, 1'b1};
        picks[2] = '1;
        picks[3] = '0;
        picks[4] = {{(W-1){1'b0}}, 1'b1};
        picks[5] = {1'b0, {(W-1){1'b1}}};
        return picks[$urandom_range(0, 5)];
    endfunction

    task automatic add_vector(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z);
        normal_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        vectors_to_send.push_back(v);
        total_vectors++;
    endtask

    task automatic add_random_vector();
        int unsigned  pick, ax, rest, ay;
        logic [W-1:0] x, y, z;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            // full-range noise
            x = W'($urandom());
            y = W'($urandom());
            z = W'($urandom());
        end
        else if (pick < 55)
        begin
            // tiny components, all-zero now and then
            x = signed_comp($urandom_range(0, 6));
            y = signed_comp($urandom_range(0, 6));
            z = signed_comp($urandom_range(0, 6));
        end
        else if (pick < 75)
        begin
            // x share straddling the fold threshold
            ax   = $urandom_range(1, 16000);
            rest = (ax * 62) / 64 + $urandom_range(0, 4);
            rest = (rest > 2) ? rest - 2 : 0;
            ay   = $urandom_range(0, rest);
            x = signed_comp(ax);
            y = signed_comp(ay);
            z = signed_comp(rest - ay);
        end
        else if (pick < 88)
        begin
            x = extreme_comp();
            y = extreme_comp();
            z = extreme_comp();
        end
        else
        begin
            // one dominant axis, the others near zero
            x = signed_comp($urandom_range(0, 32767));
            y = signed_comp($urandom_range(0, 3));
            z = signed_comp($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1)
            begin
                y = x;
                x = signed_comp($urandom_range(0, 3));
            end
        end
        add_vector(x, y, z);
    endtask

    // Idle rates by phase: receiver sparse first, then sender, then full rate
    always_comb
    begin
        if (beats_in < 190)
        begin
            send_idle_pct = 21;
            recv_idle_pct = 78;
        end
        else if (beats_in < 380)
        begin
            send_idle_pct = 78;
            recv_idle_pct = 21;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Input driver: holds a beat until accepted, then maybe loads the next
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            hold_vector = in_valid && !in_ready;
            if (in_valid && in_ready)
            begin
                expected_codes.push_back(pack_normal(comp_x, comp_y, comp_z));
                beats_in++;
            end
            if (!hold_vector)
            begin
                if (vectors_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    comp_x   <= vectors_to_send[0].x;
                    comp_y   <= vectors_to_send[0].y;
                    comp_z   <= vectors_to_send[0].z;
                    in_valid <= 1'b1;
                    void'(vectors_to_send.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                beats_out++;
                if (expected_codes.size() == 0)
                begin
                    $display("%0t: unexpected result beat code=%h zero=%b",
                             $time, packed_code, zero_vector);
                    errors++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (packed_code !== want.code)
                    begin
                        $display("%0t: packed_code expected %h actual %h",
                                 $time, want.code, packed_code);
                        errors++;
                    end
                    if (zero_vector !== want.zero)
                    begin
                        $display("%0t: zero_vector expected %b actual %b",
                                 $time, want.zero, zero_vector);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("%0t: timeout, %0d beats in, %0d out, %0d expected pending",
                         $time, beats_in, beats_out, expected_codes.size());
                $display("normal_vector_compress_core regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed: zero vector, axis extremes, most negative values, fold edges
        add_vector(16'sd0, 16'sd0, 16'sd0);
        add_vector(16'sd32767, 16'sd0, 16'sd0);
        add_vector(-16'sd32768, 16'sd0, 16'sd0);
        add_vector(16'sd0, 16'sd32767, 16'sd0);
        add_vector(16'sd0, -16'sd32768, 16'sd0);
        add_vector(16'sd0, 16'sd0, 16'sd32767);
        add_vector(16'sd0, 16'sd0, -16'sd32768);
        add_vector(-16'sd32768, -16'sd32768, -16'sd32768);
        add_vector(16'sd32767, 16'sd32767, 16'sd32767);
        add_vector(16'sd1, 16'sd0, 16'sd0);
        add_vector(-16'sd1, 16'sd0, 16'sd0);
        add_vector(16'sd0, 16'sd0, 16'sd1);
        add_vector(16'sd0, 16'sd0, -16'sd1);
        add_vector(16'sd1, 16'sd1, 16'sd1);
        add_vector(-16'sd1, -16'sd1, -16'sd1);
        add_vector(16'sd64, 16'sd0, 16'sd62);
        add_vector(16'sd63, 16'sd0, 16'sd63);
        add_vector(-16'sd64, 16'sd31, -16'sd31);
        add_vector(16'sd32767, 16'sd1, 16'sd0);
        add_vector(-16'sd32768, -16'sd32768, 16'sd0);
        add_vector(16'sd1, -16'sd32768, 16'sd0);
        add_vector(-16'sd32768, 16'sd32767, 16'sd1);
        add_vector(16'sd0, -16'sd1, 16'sd0);
        for (int i = 0; i < N_RANDOM; i++)
            add_random_vector();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_in != total_vectors || expected_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("normal_vector_compress_core regression: pass");
        else
            $display("normal_vector_compress_core regression: fail");
        $finish;
    end

endmodule
